// ===== sv/lgs_pkg.sv =====
`default_nettype none
package lgs_pkg;

	// grid geometry
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_AW   = $clog2(MAX_ROWS);
	localparam int COL_AW   = $clog2(MAX_COLS);
	localparam int CFG_W    = 7;
	// row counter wide enough for the row count and the configured value
	localparam int CNT_W    = ($clog2(MAX_ROWS + 2) > CFG_W) ? $clog2(MAX_ROWS + 2) : CFG_W;

	// stream field widths
	localparam int IDX_W    = 6;
	localparam int IN_W     = 16;
	localparam int OUT_W    = 8;

	// Life rule B3/S23
	localparam logic [3:0] BIRTH_COUNT = 4'd3;
	localparam logic [3:0] SURVIVE_LOW = 4'd2;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_GEN   = 2'd2,
		OP_CLEAR = 2'd3
	} opcode_t;

	localparam logic STATUS_DONE    = 1'b0;
	localparam logic STATUS_OUTSIDE = 1'b1;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

endpackage
`default_nettype wire

// ===== sv/life_generation_step.sv =====
`default_nettype none
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata: opcode, row_index, col_index, cell_in
// m_       out  m_tvalid/m_tready  m_tdata: cell_out, status
// cfg_     in   cfg_we             cfg_index, cfg_data (rows_in_use, cols_in_use)
//
// Write and read inside the area go through ST_ACC to ST_RESP; clear and an access
// outside the area go straight to ST_RESP; a generation goes to ST_RESP through ST_GEN_LOAD and
// ST_GEN_ROW (skipped when no area is in use): one grid RAM row read ahead, one rewritten per cycle.
// Reset clears the grid through per-row valid bits; no clearing pass.
// The input is taken only when the sequencer is idle; a finished result may
// wait in the output register while the next request is worked on.
module life_generation_step (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [lgs_pkg::IN_W-1:0] s_tdata,   // opcode[1:0] row_index[7:2] col_index[13:8] cell_in[14]
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [lgs_pkg::OUT_W-1:0]     m_tdata,   // cell_out[0] status[1]
	input  wire logic                     cfg_we,
	input  wire logic                     cfg_index,
	input  wire logic [lgs_pkg::CFG_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_GEN_LOAD,
		ST_GEN_ROW,
		ST_RESP
	} state_t;

	state_t                              state_q;
	logic [lgs_pkg::CFG_W-1:0]           rows_q;
	logic [lgs_pkg::CFG_W-1:0]           cols_q;
	lgs_pkg::opcode_t                    op_q;
	logic [lgs_pkg::IDX_W-1:0]           row_q;
	logic [lgs_pkg::IDX_W-1:0]           col_q;
	logic                                cell_q;
	logic [lgs_pkg::CNT_W-1:0]           r_q;
	logic [lgs_pkg::MAX_COLS-1:0]        above_q;
	logic [lgs_pkg::MAX_COLS-1:0]        here_q;
	logic                                res_cell_q;
	logic                                res_status_q;
	logic [lgs_pkg::MAX_ROWS-1:0]        valid_q;
	logic                                rd_valid_s1;
	logic                                m_tvalid_q;
	logic [lgs_pkg::OUT_W-1:0]           m_tdata_q;

	lgs_pkg::opcode_t                    s_op;
	logic [lgs_pkg::IDX_W-1:0]           s_row;
	logic [lgs_pkg::IDX_W-1:0]           s_col;
	logic                                s_cell;
	logic                                accept;
	logic [lgs_pkg::CNT_W-1:0]           eff_rows;
	logic [lgs_pkg::CFG_W-1:0]           eff_cols;
	logic [lgs_pkg::MAX_COLS-1:0]        mask;
	logic                                s_outside;
	logic                                gen_empty;
	logic [lgs_pkg::ROW_AW-1:0]          rd_addr;
	logic [lgs_pkg::ROW_AW-1:0]          wr_addr;
	logic [lgs_pkg::MAX_COLS-1:0]        wr_data;
	logic                                wr_en;
	logic [lgs_pkg::MAX_COLS-1:0]        ram_rdata;
	logic [lgs_pkg::MAX_COLS-1:0]        row_rd;
	logic [lgs_pkg::MAX_COLS-1:0]        below;
	logic [lgs_pkg::MAX_COLS-1:0]        next_row;
	logic [lgs_pkg::CNT_W-1:0]           r_next;
	logic [lgs_pkg::CNT_W-1:0]           r_ahead;
	logic [lgs_pkg::CNT_W-1:0]           row_ext;
	logic                                out_free;

	// input fields
	assign s_op   = lgs_pkg::opcode_t'(s_tdata[1:0]);
	assign s_row  = s_tdata[7:2];
	assign s_col  = s_tdata[13:8];
	assign s_cell = s_tdata[14];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// effective area in use
	assign eff_rows = (lgs_pkg::CNT_W'(rows_q) > lgs_pkg::CNT_W'(lgs_pkg::MAX_ROWS))
		? lgs_pkg::CNT_W'(lgs_pkg::MAX_ROWS) : lgs_pkg::CNT_W'(rows_q);
	assign eff_cols = (cols_q > lgs_pkg::CFG_W'(lgs_pkg::MAX_COLS))
		? lgs_pkg::CFG_W'(lgs_pkg::MAX_COLS) : cols_q;

	always_comb begin
		for (int c = 0; c < lgs_pkg::MAX_COLS; c++) begin
			mask[c] = (lgs_pkg::CFG_W'(c) < eff_cols);
		end
	end

	assign s_outside = (lgs_pkg::CNT_W'(s_row) >= eff_rows)
		|| ({1'b0, s_col} >= eff_cols);
	assign gen_empty = (eff_rows == '0) || (eff_cols == '0);

	// row sequencing
	assign r_next  = r_q + lgs_pkg::CNT_W'(1);
	assign r_ahead = r_q + lgs_pkg::CNT_W'(2);
	assign row_ext = lgs_pkg::CNT_W'(row_q);

	// RAM read address: request row on accept, read-ahead during a generation
	always_comb begin
		unique case (state_q)
			ST_IDLE:     rd_addr = (s_op == lgs_pkg::OP_GEN) ? '0 : s_row[lgs_pkg::ROW_AW-1:0];
			ST_GEN_LOAD: rd_addr = r_next[lgs_pkg::ROW_AW-1:0];
			ST_GEN_ROW:  rd_addr = r_ahead[lgs_pkg::ROW_AW-1:0];
			default:     rd_addr = r_next[lgs_pkg::ROW_AW-1:0];
		endcase
	end

	// rows never written since reset or clear read as dead
	assign row_rd = rd_valid_s1 ? ram_rdata : '0;
	assign below  = (r_next < eff_rows) ? (row_rd & mask) : '0;

	lgs_row_unit u_row (
		.above    (above_q),
		.here     (here_q & mask),
		.below    (below),
		.mask     (mask),
		.next_row (next_row)
	);

	// RAM write: single-cell update or one generated row
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = row_ext[lgs_pkg::ROW_AW-1:0];
		wr_data = row_rd;
		if (state_q == ST_ACC && op_q == lgs_pkg::OP_WRITE) begin
			wr_en = 1'b1;
			wr_data[col_q[lgs_pkg::COL_AW-1:0]] = cell_q;
		end else if (state_q == ST_GEN_ROW) begin
			wr_en   = 1'b1;
			wr_addr = r_q[lgs_pkg::ROW_AW-1:0];
			wr_data = (here_q & ~mask) | next_row;
		end
	end

	lgs_ram #(
		.WIDTH (lgs_pkg::MAX_COLS),
		.DEPTH (lgs_pkg::MAX_ROWS)
	) u_grid (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// sequencer, valid bits and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rows_q       <= lgs_pkg::CFG_W'(64);
			cols_q       <= lgs_pkg::CFG_W'(64);
			valid_q      <= '0;
			rd_valid_s1  <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			op_q         <= lgs_pkg::OP_WRITE;
			r_q          <= '0;
			above_q      <= '0;
			here_q       <= '0;
			res_cell_q   <= 1'b0;
			res_status_q <= lgs_pkg::STATUS_DONE;
		end else begin
			rd_valid_s1 <= valid_q[rd_addr];
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			// result register: loaded from ST_RESP, dropped once taken
			if (state_q == ST_RESP && out_free) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {{(lgs_pkg::OUT_W-2){1'b0}}, res_status_q, res_cell_q};
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == lgs_pkg::REG_ROWS) begin
					rows_q <= cfg_data;
				end else begin
					cols_q <= cfg_data;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q         <= s_op;
						res_cell_q   <= 1'b0;
						res_status_q <= lgs_pkg::STATUS_DONE;
						r_q          <= '0;
						unique case (s_op)
							lgs_pkg::OP_WRITE, lgs_pkg::OP_READ: begin
								if (s_outside) begin
									res_status_q <= lgs_pkg::STATUS_OUTSIDE;
									state_q      <= ST_RESP;
								end else begin
									state_q <= ST_ACC;
								end
							end
							lgs_pkg::OP_GEN: begin
								state_q <= gen_empty ? ST_RESP : ST_GEN_LOAD;
							end
							lgs_pkg::OP_CLEAR: begin
								valid_q <= '0;
								state_q <= ST_RESP;
							end
							default: state_q <= ST_RESP;
						endcase
					end
				end
				ST_ACC: begin
					if (op_q == lgs_pkg::OP_READ) begin
						res_cell_q <= row_rd[col_q[lgs_pkg::COL_AW-1:0]];
					end
					state_q <= ST_RESP;
				end
				ST_GEN_LOAD: begin
					above_q <= '0;
					here_q  <= row_rd;
					state_q <= ST_GEN_ROW;
				end
				ST_GEN_ROW: begin
					above_q <= here_q & mask;
					here_q  <= row_rd;
					r_q     <= r_next;
					if (r_next >= eff_rows) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// latched request fields
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q  <= s_row;
			col_q  <= s_col;
			cell_q <= s_cell;
		end
	end

endmodule
`default_nettype wire

// ===== sv/lgs_ram.sv =====
`default_nettype none
module lgs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/lgs_row_unit.sv =====
`default_nettype none
module lgs_row_unit (
	input  wire logic [lgs_pkg::MAX_COLS-1:0] above,
	input  wire logic [lgs_pkg::MAX_COLS-1:0] here,
	input  wire logic [lgs_pkg::MAX_COLS-1:0] below,
	input  wire logic [lgs_pkg::MAX_COLS-1:0] mask,
	output logic      [lgs_pkg::MAX_COLS-1:0] next_row
);

	logic [lgs_pkg::MAX_COLS+1:0] ap;
	logic [lgs_pkg::MAX_COLS+1:0] hp;
	logic [lgs_pkg::MAX_COLS+1:0] bp;

	// dead border on both sides of each row
	assign ap = {1'b0, above, 1'b0};
	assign hp = {1'b0, here, 1'b0};
	assign bp = {1'b0, below, 1'b0};

	// neighbour count and B3/S23 per column, columns independent
	always_comb begin
		logic [3:0] n;
		next_row = '0;
		for (int c = 0; c < lgs_pkg::MAX_COLS; c++) begin
			n = 4'(ap[c]) + 4'(ap[c+1]) + 4'(ap[c+2])
			  + 4'(hp[c]) + 4'(hp[c+2])
			  + 4'(bp[c]) + 4'(bp[c+1]) + 4'(bp[c+2]);
			next_row[c] = mask[c] & ((n == lgs_pkg::BIRTH_COUNT)
				| (here[c] & (n == lgs_pkg::SURVIVE_LOW)));
		end
	end

endmodule
`default_nettype wire
